>>> sv/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants
// Beat formats, cell data and controller states of the trial-division table.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 11;
  localparam int TABLE_DEPTH_D = 1024;

  localparam logic KIND_EXTEND = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] prime_count;
    logic [VALUE_BITS-1:0] largest_prime;
    logic                  table_full;
  } out_result_t;

  // One beat travelling down the remainder chain.
  typedef struct packed {
    logic                  v;
    logic [VALUE_BITS-1:0] rem;
    logic [VALUE_BITS-1:0] dvs;
    logic [VALUE_BITS-1:0] dvd;
  } cell_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT_NEXT,
    ST_EXT_FEED,
    ST_EXT_WAIT,
    ST_LK_CHK,
    ST_LK_CMP,
    ST_DONE
  } state_t;

endpackage

>>> sv/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell: one restoring-remainder step
// Shift in one dividend bit, subtract the divisor when it fits, register.
// ----------------------------------------------------------------------------
module ptd_cell #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptd_pkg::cell_data_t d_in,
  output ptd_pkg::cell_data_t d_out
);

  localparam int VB = ptd_pkg::VALUE_BITS;

  ptd_pkg::cell_data_t d_r, d_nxt;
  logic [VB:0] trial;

  always_comb begin
    trial = {d_in.rem, d_in.dvd[BIT]};
    if (trial >= {1'b0, d_in.dvs}) begin
      trial = trial - {1'b0, d_in.dvs};
    end
    d_nxt     = d_in;
    d_nxt.rem = trial[VB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.v <= 1'b0;
    end else begin
      d_r.v <= d_nxt.v;
    end
    d_r.rem <= d_nxt.rem;
    d_r.dvs <= d_nxt.dvs;
    d_r.dvd <= d_nxt.dvd;
  end

  assign d_out = d_r;

endmodule

>>> sv/ptd_chain.sv
// ----------------------------------------------------------------------------
// ptd_chain: row of remainder cells
// One cell per dividend bit, most significant first; a beat leaves with
// the full remainder of dividend by divisor.
// ----------------------------------------------------------------------------
module ptd_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  ptd_pkg::cell_data_t d_in,
  output ptd_pkg::cell_data_t d_out
);

  localparam int VB = ptd_pkg::VALUE_BITS;

  ptd_pkg::cell_data_t link [VB+1];

  assign link[0] = d_in;

  for (genvar k = 0; k < VB; k++) begin : g_cell
    ptd_cell #(.BIT(VB-1-k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (link[k]),
      .d_out (link[k+1])
    );
  end

  assign d_out = link[VB];

endmodule

>>> sv/prime_table_trial_division_unit.sv
// ----------------------------------------------------------------------------
// prime_table_trial_division_unit: trial-division prime table
// Holds an ascending table of primes; extends it up to a bound or looks a
// value up in it.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken on an edge where busy
//   is low. kind = extend adds every prime above the largest one up to
//   in_item.value until the table fills; kind = lookup binary-searches it.
//   Each request gives one result beat on out_result, marked by out_valid
//   for exactly one cycle. The receiver cannot stall: take it then.
// Timing:
//   Each extend candidate streams every stored prime, one per cycle, from
//   the table memory into a row of VALUE_BITS remainder cells; an empty
//   table skips the feed. Each lookup search step reads the table memory,
//   then compares.
//   Requests are worked one at a time; busy stays high until the result.
// Reset:
//   Synchronous, active low: the table is empty, largest prime reads 1.
//   Table contents need no clearing; only entries below the count are read.
// ----------------------------------------------------------------------------
module prime_table_trial_division_unit #(
  parameter int TABLE_DEPTH = ptd_pkg::TABLE_DEPTH_D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ptd_pkg::in_item_t    in_item,
  output logic                 busy,
  output logic                 out_valid,
  output ptd_pkg::out_result_t out_result
);

  localparam int VB = ptd_pkg::VALUE_BITS;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Prime table memory: one write port, one registered read port.
  logic [VB-1:0] mem [TABLE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [VB-1:0] rd_data_r;
  logic          wr_en;

  ptd_pkg::state_t state_r, state_nxt;

  logic          kind_r,    kind_nxt;
  logic [VB-1:0] bound_r,   bound_nxt;
  logic [VB-1:0] cand_r,    cand_nxt;
  logic [VB-1:0] last_r,    last_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic [CW-1:0] idx_r,     idx_nxt;
  logic [CW-1:0] resp_r,    resp_nxt;
  logic          div_r,     div_nxt;
  logic [CW-1:0] lo_r,      lo_nxt;
  logic [CW-1:0] hi_r,      hi_nxt;
  logic [CW-1:0] mid_r,     mid_nxt;
  logic          found_r,   found_nxt;
  logic          feed_v_r;

  logic [CW-1:0] mid;
  logic          more_cand;

  ptd_pkg::cell_data_t chain_in, chain_out;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign more_cand = (cand_r < bound_r) && (count_r != DEPTH_C);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_item.kind == ptd_pkg::KIND_LOOKUP) ? ptd_pkg::ST_LK_CHK
                                                               : ptd_pkg::ST_EXT_NEXT;
        end
      end
      ptd_pkg::ST_EXT_NEXT: begin
        if (!more_cand) begin
          state_nxt = ptd_pkg::ST_DONE;
        end else if (count_r == '0) begin
          state_nxt = ptd_pkg::ST_EXT_WAIT;
        end else begin
          state_nxt = ptd_pkg::ST_EXT_FEED;
        end
      end
      ptd_pkg::ST_EXT_FEED: begin
        if (idx_r == count_r - 1'b1) state_nxt = ptd_pkg::ST_EXT_WAIT;
      end
      ptd_pkg::ST_EXT_WAIT: begin
        if (resp_r == count_r) state_nxt = ptd_pkg::ST_EXT_NEXT;
      end
      ptd_pkg::ST_LK_CHK: begin
        state_nxt = (lo_r < hi_r) ? ptd_pkg::ST_LK_CMP : ptd_pkg::ST_DONE;
      end
      ptd_pkg::ST_LK_CMP: begin
        state_nxt = (rd_data_r == bound_r) ? ptd_pkg::ST_DONE : ptd_pkg::ST_LK_CHK;
      end
      ptd_pkg::ST_DONE: begin
        state_nxt = ptd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    busy      = (state_r != ptd_pkg::ST_IDLE);
    out_valid = (state_r == ptd_pkg::ST_DONE);
    wr_en     = (state_r == ptd_pkg::ST_EXT_WAIT) && (resp_r == count_r) && !div_r;
    rd_addr   = (state_r == ptd_pkg::ST_LK_CHK) ? mid[AW-1:0] : idx_r[AW-1:0];
  end

  // Datapath next values.
  always_comb begin
    kind_nxt  = kind_r;
    bound_nxt = bound_r;
    cand_nxt  = cand_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    resp_nxt  = resp_r;
    div_nxt   = div_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    found_nxt = found_r;

    // Collect remainder beats leaving the chain.
    if (chain_out.v) begin
      resp_nxt = resp_r + 1'b1;
      if (chain_out.rem == '0) div_nxt = 1'b1;
    end

    case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_item.kind;
          bound_nxt = in_item.value;
          cand_nxt  = last_r;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          found_nxt = 1'b0;
        end
      end
      ptd_pkg::ST_EXT_NEXT: begin
        idx_nxt  = '0;
        resp_nxt = '0;
        div_nxt  = 1'b0;
        if (more_cand) cand_nxt = cand_r + 1'b1;
      end
      ptd_pkg::ST_EXT_FEED: begin
        idx_nxt = idx_r + 1'b1;
      end
      ptd_pkg::ST_EXT_WAIT: begin
        // Append the candidate when no stored prime divides it.
        if (wr_en) begin
          count_nxt = count_r + 1'b1;
          last_nxt  = cand_r;
        end
      end
      ptd_pkg::ST_LK_CHK: begin
        mid_nxt = mid;
      end
      ptd_pkg::ST_LK_CMP: begin
        if (rd_data_r == bound_r) begin
          found_nxt = 1'b1;
        end else if (rd_data_r < bound_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ptd_pkg::ST_IDLE;
      count_r  <= '0;
      last_r   <= VB'(1);
      feed_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      feed_v_r <= (state_r == ptd_pkg::ST_EXT_FEED);
    end
    kind_r  <= kind_nxt;
    bound_r <= bound_nxt;
    cand_r  <= cand_nxt;
    idx_r   <= idx_nxt;
    resp_r  <= resp_nxt;
    div_r   <= div_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= cand_r;
    rd_data_r <= mem[rd_addr];
  end

  // Feed each stored prime, one per cycle, against the current candidate.
  assign chain_in.v   = feed_v_r;
  assign chain_in.rem = '0;
  assign chain_in.dvs = rd_data_r;
  assign chain_in.dvd = cand_r;

  ptd_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (chain_in),
    .d_out (chain_out)
  );

  assign out_result.found         = found_r & (kind_r == ptd_pkg::KIND_LOOKUP);
  assign out_result.prime_count   = ptd_pkg::COUNT_BITS'(count_r);
  assign out_result.largest_prime = last_r;
  assign out_result.table_full    = (count_r == DEPTH_C);

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: prime table trial-division unit testbench
// Drives extend and lookup requests through the start/busy handshake and
// checks every result beat against an in-bench prime table predictor: the
// empty table, small extends, random growth, filling the table, and use of
// the full table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = ptd_pkg::TABLE_DEPTH_D;
  localparam int GROW_CAP    = 400;        // stop growing the table in the random part
  localparam longint LIMIT   = 40_000_000; // watchdog bound; filling the table is slow, so allow plenty
  localparam int DRAIN_EXTRA = 64;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  ptd_pkg::in_item_t    in_item;
  logic                 busy;
  logic                 out_valid;
  ptd_pkg::out_result_t out_result;

  prime_table_trial_division_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Predictor state: stored primes, their count and the largest one.
  longint               primes_held[$];
  longint               top_prime;
  ptd_pkg::out_result_t pending_results[$];
  int                   error_count;
  longint               cycle_count;
  bit                   idle_on;

  function automatic bit divides_any(longint cand);
    foreach (primes_held[i]) begin
      if (cand % primes_held[i] == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the predictor and return the result it gives.
  function automatic ptd_pkg::out_result_t predict_request(ptd_pkg::in_item_t item);
    ptd_pkg::out_result_t res;
    longint               cand;
    bit                   hit;
    hit = 1'b0;
    if (item.kind == ptd_pkg::KIND_EXTEND) begin
      cand = top_prime;
      while (cand < longint'(item.value) && primes_held.size() < DEPTH) begin
        cand++;
        if (!divides_any(cand)) begin
          primes_held.push_back(cand);
          top_prime = cand;
        end
      end
    end else begin
      foreach (primes_held[i]) begin
        if (primes_held[i] == longint'(item.value)) hit = 1'b1;
      end
    end
    res.found         = hit;
    res.prime_count   = ptd_pkg::COUNT_BITS'(primes_held.size());
    res.largest_prime = ptd_pkg::VALUE_BITS'(top_prime);
    res.table_full    = (primes_held.size() >= DEPTH);
    return res;
  endfunction

  // Send one beat; start stays high for a back-to-back next beat unless idle_on adds a gap.
  task automatic send_item(logic kind, logic [ptd_pkg::VALUE_BITS-1:0] value);
    ptd_pkg::in_item_t item;
    item.kind  = kind;
    item.value = value;
    in_item <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_request(item));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Pick a lookup value near the interesting points of the table.
  function automatic logic [ptd_pkg::VALUE_BITS-1:0] pick_lookup();
    longint p;
    if (primes_held.size() == 0 || $urandom_range(0, 3) == 0) return $urandom;
    p = primes_held[$urandom_range(0, primes_held.size() - 1)];
    case ($urandom_range(0, 3))
      0:       return ptd_pkg::VALUE_BITS'(p - 1);
      1:       return ptd_pkg::VALUE_BITS'(p + 1);
      default: return ptd_pkg::VALUE_BITS'(p);
    endcase
  endfunction

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    ptd_pkg::out_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result.found !== want.found) begin
          $display("%0t: found exp %0d act %0d", $time, want.found, out_result.found);
          error_count++;
        end
        if (out_result.prime_count !== want.prime_count) begin
          $display("%0t: prime_count exp %0d act %0d", $time,
                   want.prime_count, out_result.prime_count);
          error_count++;
        end
        if (out_result.largest_prime !== want.largest_prime) begin
          $display("%0t: largest_prime exp %0d act %0d", $time,
                   want.largest_prime, out_result.largest_prime);
          error_count++;
        end
        if (out_result.table_full !== want.table_full) begin
          $display("%0t: table_full exp %0d act %0d", $time,
                   want.table_full, out_result.table_full);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Empty table: lookups miss, small bounds add nothing.
  task automatic test_empty_table();
    send_item(ptd_pkg::KIND_LOOKUP, 0);
    send_item(ptd_pkg::KIND_LOOKUP, 2);
    send_item(ptd_pkg::KIND_EXTEND, 0);
    send_item(ptd_pkg::KIND_EXTEND, 1);
    send_item(ptd_pkg::KIND_LOOKUP, '1);
    send_item(ptd_pkg::KIND_LOOKUP, 1);
  endtask

  // First primes, repeated and lower bounds, lookups on both sides.
  task automatic test_small_extends();
    send_item(ptd_pkg::KIND_EXTEND, 2);
    send_item(ptd_pkg::KIND_LOOKUP, 2);
    send_item(ptd_pkg::KIND_EXTEND, 3);
    send_item(ptd_pkg::KIND_EXTEND, 30);
    send_item(ptd_pkg::KIND_LOOKUP, 29);
    send_item(ptd_pkg::KIND_LOOKUP, 27);
    send_item(ptd_pkg::KIND_LOOKUP, 31);
    send_item(ptd_pkg::KIND_EXTEND, 30);
    send_item(ptd_pkg::KIND_EXTEND, 5);
    send_item(ptd_pkg::KIND_EXTEND, 0);
    send_item(ptd_pkg::KIND_LOOKUP, 32'h8000_0002);
    send_item(ptd_pkg::KIND_EXTEND, 32);
    send_item(ptd_pkg::KIND_LOOKUP, 31);
    drain_results();
  endtask

  // Mostly slow growth of the table with lookups around it.
  task automatic test_random_growth(int count);
    longint bound;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        if (primes_held.size() < GROW_CAP && $urandom_range(0, 9) != 0)
          bound = top_prime + $urandom_range(0, 40);
        else
          bound = $urandom_range(0, int'(top_prime));
        send_item(ptd_pkg::KIND_EXTEND, ptd_pkg::VALUE_BITS'(bound));
      end else begin
        send_item(ptd_pkg::KIND_LOOKUP, pick_lookup());
      end
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  // Huge bound: scan stops once the table fills.
  task automatic test_fill_table();
    send_item(ptd_pkg::KIND_EXTEND, '1);
    send_item(ptd_pkg::KIND_LOOKUP, ptd_pkg::VALUE_BITS'(top_prime));
    send_item(ptd_pkg::KIND_LOOKUP, ptd_pkg::VALUE_BITS'(top_prime + 6));
    send_item(ptd_pkg::KIND_EXTEND, '1);
    send_item(ptd_pkg::KIND_LOOKUP, 2);
    drain_results();
  endtask

  // Full table: any value, both kinds.
  task automatic test_full_table(int count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) send_item(ptd_pkg::KIND_EXTEND, $urandom);
      else                           send_item(ptd_pkg::KIND_LOOKUP, pick_lookup());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    error_count = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    top_prime   = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_small_extends();
    test_random_growth(420);
    test_fill_table();
    test_full_table(80);
    idle_on = 1'b0;
    test_full_table(60);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_EXTRA) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else                  $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
sv/ptd_pkg.sv
sv/ptd_cell.sv
sv/ptd_chain.sv
sv/prime_table_trial_division_unit.sv
bench/tb_top.sv
